/* sv/assert_macros.svh */
// assertion macros used by the top level of the two-class priority queue
// every macro samples on aclk and is disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define TCPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TCPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tcpq_pkg.sv */
// shared types and constants for the two-class priority queue
// no dependencies; imported by tcpq_cell and two_class_priority_queue_top
package tcpq_pkg;

    localparam int DEPTH     = 16;
    localparam int KEY_W     = 30;
    localparam int REG_W     = 5;
    localparam int COUNT_W   = 5;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMP_W     = (CNT_W > REG_W) ? CNT_W : REG_W;
    localparam int MAX_RESET = 10;

    typedef enum logic [1:0] {
        OP_INS_NORMAL = 2'd0,
        OP_INS_URGENT = 2'd1,
        OP_DEQUEUE    = 2'd2,
        OP_CANCEL     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             urgent;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic             ins;
        logic             rem;
        op_t              op;
        logic [KEY_W-1:0] key;
    } cell_ctrl_t;

endpackage

/* sv/two_class_priority_queue_top.sv */
// top level of the two-class priority queue: cell chain, count, limit
// register and output register; depends on tcpq_pkg, tcpq_cell and
// assert_macros.svh
//
//  channel | direction | tdata (low bit up)                      | tuser
//  s_      | in        | key[29:0], pad                          | op[1:0]
//  m_      | out       | out_key[29:0], out_urgent, count[4:0]   | status[1:0]
//  cfg_    | in        | max_entries[4:0] on cfg_wr_data         | -
//
// one request is taken per cycle; the search ripples through the cell chain
// from the head; cells from the found slot on shift in the same cycle the request is taken
// the result appears in the output register the cycle after the request
// a new request is taken while the output register is empty or being read
// aresetn (synchronous, active low) empties the queue and sets the limit to 10
`include "assert_macros.svh"

module two_class_priority_queue_top import tcpq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration: capacity limit
    input  logic                 cfg_wr_en,
    input  logic [REG_W-1:0]     cfg_wr_data,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // key[29:0], zero pad[31:30]
    input  logic [1:0]           s_tuser,   // op[1:0]
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // out_key[29:0], out_urgent[30],
                                            // count[35:31], zero pad[39:36]
    output logic [1:0]           m_tuser    // status[1:0]
);

    // queue state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [REG_W-1:0] max_entries_reg;

    // output register
    logic             m_valid_reg;
    status_t          m_status_reg;
    status_t          m_status_next;
    logic [KEY_W-1:0] m_key_reg;
    logic [KEY_W-1:0] m_key_next;
    logic             m_urgent_reg;
    logic             m_urgent_next;
    logic [CNT_W-1:0] m_count_reg;

    // request decode
    logic             accept;
    op_t              req_op;
    logic [KEY_W-1:0] req_key;
    logic             is_ins;
    logic [CMP_W-1:0] limit;
    logic             full;
    logic             empty;
    logic             found;
    cell_ctrl_t       ctrl;

    // chain wiring, index DEPTH is the tail end
    entry_t           cell_entry [DEPTH];
    logic             found_chain [DEPTH+1];
    entry_t           sel_chain [DEPTH+1];
    logic             occupied [DEPTH];

    assign req_op  = op_t'(s_tuser);
    assign req_key = s_tdata[KEY_W-1:0];
    assign accept  = s_tvalid && s_tready;
    assign is_ins  = (req_op == OP_INS_NORMAL) || (req_op == OP_INS_URGENT);

    // limit in use is clamped to the number of cells
    assign limit = (CMP_W'(max_entries_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                             : CMP_W'(max_entries_reg);
    assign full  = CMP_W'(count_reg) >= limit;
    assign empty = (count_reg == '0);
    assign found = found_chain[DEPTH];

    assign ctrl.op  = req_op;
    assign ctrl.key = req_key;
    assign ctrl.ins = accept && is_ins && !full;
    assign ctrl.rem = accept && !is_ins && !empty && found;

    assign found_chain[0] = 1'b0;
    assign sel_chain[0]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            // a slot holds an entry when it lies below the count
            assign occupied[gi] = CNT_W'(gi) < count_reg;

            tcpq_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .occupied    (occupied[gi]),
                .left_entry  ((gi == 0) ? cell_entry[0] : cell_entry[(gi == 0) ? 0 : gi-1]),
                .right_entry (cell_entry[(gi == DEPTH-1) ? gi : gi+1]),
                .found_in    (found_chain[gi]),
                .sel_in      (sel_chain[gi]),
                .entry       (cell_entry[gi]),
                .found_out   (found_chain[gi+1]),
                .sel_out     (sel_chain[gi+1])
            );
        end
    endgenerate

    // count and result of the request
    always_comb begin
        count_next    = count_reg;
        m_status_next = ST_OK;
        m_key_next    = '0;
        m_urgent_next = 1'b0;
        if (is_ins) begin
            if (full) begin
                m_status_next = ST_FULL;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else if (empty) begin
            m_status_next = ST_EMPTY;
        end else if (!found) begin
            m_status_next = ST_NOTFOUND;
        end else begin
            count_next    = count_reg - CNT_W'(1);
            m_key_next    = sel_chain[DEPTH].key;
            m_urgent_next = sel_chain[DEPTH].urgent;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            max_entries_reg <= REG_W'(MAX_RESET);
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_entries_reg <= cfg_wr_data;
            end
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status_reg <= m_status_next;
            m_key_reg    <= m_key_next;
            m_urgent_reg <= m_urgent_next;
            m_count_reg  <= count_next;
        end
    end

    // take a new request while the result register is free or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'b0000, COUNT_W'(m_count_reg), m_urgent_reg, m_key_reg};

    // occupancy never passes the number of cells
    `TCPQ_ASSERT(a_count_bound, (CMP_W'(count_reg) <= CMP_W'(DEPTH)),
        "queue count exceeds depth")

    // an accepted insert below the limit grows the queue by one
    `TCPQ_ASSERT_NEXT(a_ins_grows, (accept && is_ins && !full),
        (count_reg == $past(count_reg) + CNT_W'(1)), "insert did not grow queue")

    // dequeue or cancel on an empty queue reports empty
    `TCPQ_ASSERT_NEXT(a_empty_report, (accept && !is_ins && empty),
        (m_tvalid && m_tuser == ST_EMPTY && count_reg == '0), "empty not reported")

endmodule

/* sv/tcpq_cell.sv */
// one slot of the queue: holds an entry, finds the operation's position by
// a ripple from the head, and shifts toward or away from the head on commit
// depends on tcpq_pkg
module tcpq_cell import tcpq_pkg::*; (
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    input  logic       found_in,
    input  entry_t     sel_in,
    output entry_t     entry,
    output logic       found_out,
    output entry_t     sel_out
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   cand;
    logic   hit;

    // is this slot a candidate position for the operation
    always_comb begin
        case (ctrl.op)
            OP_INS_NORMAL: cand = !occupied;
            OP_INS_URGENT: cand = !(occupied && entry_reg.urgent);
            OP_DEQUEUE:    cand = 1'b1;
            OP_CANCEL:     cand = occupied && (entry_reg.key == ctrl.key);
            default:       cand = 1'b0;
        endcase
    end

    assign hit       = cand && !found_in;
    assign found_out = found_in || cand;
    assign sel_out   = hit ? entry_reg : sel_in;
    assign entry     = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (found_in) begin
                entry_next = left_entry;
            end else if (hit) begin
                entry_next.key    = ctrl.key;
                entry_next.urgent = (ctrl.op == OP_INS_URGENT);
            end
        end else if (ctrl.rem && found_out) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule
